FILE: design/tes_pkg.sv
// Shared types, constants and register codes for the twist EMA smoother.
`timescale 1ns / 1ps

package tes_pkg;

   // Velocity word width and Q1.16 weight format
   localparam int VEL_WIDTH   = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ALPHA_WIDTH = FRAC_BITS + 1;
   localparam int HOLD_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE   = ALPHA_WIDTH'(1) << FRAC_BITS;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_WIDTH'(26214);
   localparam logic [HOLD_WIDTH-1:0]  HOLD_RESET  = HOLD_WIDTH'(10);

   // Word modes
   localparam logic MODE_COMMAND = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_LINEAR  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_ANGULAR = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS    = CSR_INDEX_WIDTH'(2);

   typedef logic signed [VEL_WIDTH-1:0] vel_type;

   typedef struct packed {
      logic    mode;
      vel_type vel_x;
      vel_type vel_y;
      vel_type vel_yaw;
   } req_word_type;

   typedef struct packed {
      vel_type smooth_x;
      vel_type smooth_y;
      vel_type smooth_yaw;
   } rsp_word_type;

   typedef struct packed {
      logic [ALPHA_WIDTH-1:0] alpha_linear;
      logic [ALPHA_WIDTH-1:0] alpha_angular;
      logic [HOLD_WIDTH-1:0]  hold_ticks;
   } cfg_type;

endpackage

FILE: design/tes_csr_regs.sv
// Configuration registers: smoothing weights and hold reload value.
`timescale 1ns / 1ps

module tes_csr_regs
   import tes_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ALPHA_WIDTH-1:0]     csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA_LINEAR:  cfg_in.alpha_linear  = csr_data;
            CSR_ALPHA_ANGULAR: cfg_in.alpha_angular = csr_data;
            CSR_HOLD_TICKS:    cfg_in.hold_ticks    = csr_data[HOLD_WIDTH-1:0];
            default:           cfg_in = cfg_ff;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_linear  <= ALPHA_RESET;
         cfg_ff.alpha_angular <= ALPHA_RESET;
         cfg_ff.hold_ticks    <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/tes_ema_lane.sv
// One EMA lane: s = floor(prev + a * (cmd - prev) + 1/2), saturated.
`timescale 1ns / 1ps

module tes_ema_lane
   import tes_pkg::*;
(
   input  logic [ALPHA_WIDTH-1:0] alpha,
   input  vel_type                cmd,
   input  vel_type                prev,
   output vel_type                smooth
);

   localparam int PROD_WIDTH = ALPHA_WIDTH + 1 + VEL_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam int Q_WIDTH    = SUM_WIDTH - FRAC_BITS;
   localparam int EXT_BITS   = SUM_WIDTH - VEL_WIDTH - FRAC_BITS;

   logic [ALPHA_WIDTH-1:0]        alpha_eff;
   logic signed [VEL_WIDTH:0]     diff;
   logic signed [PROD_WIDTH-1:0]  prod;
   logic signed [SUM_WIDTH-1:0]   base;
   logic signed [SUM_WIDTH-1:0]   sum;
   logic signed [Q_WIDTH-1:0]     q;
   logic                          in_range;

   always_comb begin
      alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      diff      = {cmd[VEL_WIDTH-1], cmd} - {prev[VEL_WIDTH-1], prev};
      prod      = $signed({1'b0, alpha_eff}) * diff;
      base      = {{EXT_BITS{prev[VEL_WIDTH-1]}}, prev, {FRAC_BITS{1'b0}}};
      sum       = base + {prod[PROD_WIDTH-1], prod}
                + $signed(SUM_WIDTH'(1) << (FRAC_BITS - 1));
      q         = sum[SUM_WIDTH-1:FRAC_BITS];   // arithmetic floor
      // in range when all bits above the result's sign agree with it
      in_range  = (q[Q_WIDTH-1:VEL_WIDTH-1] == '0) || (q[Q_WIDTH-1:VEL_WIDTH-1] == '1);
      if (in_range) begin
         smooth = q[VEL_WIDTH-1:0];
      end else if (q[Q_WIDTH-1]) begin
         smooth = {1'b1, {(VEL_WIDTH-1){1'b0}}};
      end else begin
         smooth = {1'b0, {(VEL_WIDTH-1){1'b1}}};
      end
   end

endmodule

FILE: design/twist_ema_smoother_with_timeout.sv
// Twist smoother top level: input register, hold timer, three EMA lanes, result register.
// Path: a tick enters the input register, then its result is written to the result register.
// Throughput: one word per clock; a tick waits only while a stalled result holds the output
//   register. The prev feedback is one 17x17 multiply-add per lane. Commands give no result.
// Reset (synchronous, active high): held command, smoothed values and hold counter clear to
//   zero, weights load 0.4 (26214), hold reload loads 10; no result pending.
`timescale 1ns / 1ps

module twist_ema_smoother_with_timeout
   import tes_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_word,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_word,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ALPHA_WIDTH-1:0]     csr_data
);

   cfg_type cfg;

   // Input register
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;

   // Filter state
   vel_type                held_x_ff, held_y_ff, held_yaw_ff;
   vel_type                held_x_in, held_y_in, held_yaw_in;
   vel_type                prev_x_ff, prev_y_ff, prev_yaw_ff;
   vel_type                prev_x_in, prev_y_in, prev_yaw_in;
   logic [HOLD_WIDTH-1:0]  hold_count_ff, hold_count_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic    out_free, s1_is_tick, s1_fire, tick_fire, cmd_fire, timed_out;
   vel_type cur_x, cur_y, cur_yaw;
   vel_type lane_x, lane_y, lane_yaw;

   tes_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: the result register is free when empty or being drained this cycle.
   // A command word never needs it, so it can retire even under a stalled result.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_is_tick = (s1_word_ff.mode == MODE_TICK);
   assign s1_fire    = s1_valid_ff && (!s1_is_tick || out_free);
   assign tick_fire  = s1_fire && s1_is_tick;
   assign cmd_fire   = s1_fire && !s1_is_tick;
   assign req_ready  = !s1_valid_ff || s1_fire;

   // Timeout: once the counter has run out, the held command reads as zero
   assign timed_out = (hold_count_ff == '0);
   assign cur_x     = timed_out ? vel_type'(0) : held_x_ff;
   assign cur_y     = timed_out ? vel_type'(0) : held_y_ff;
   assign cur_yaw   = timed_out ? vel_type'(0) : held_yaw_ff;

   tes_ema_lane u_lane_x (
      .alpha  (cfg.alpha_linear),
      .cmd    (cur_x),
      .prev   (prev_x_ff),
      .smooth (lane_x)
   );

   tes_ema_lane u_lane_y (
      .alpha  (cfg.alpha_linear),
      .cmd    (cur_y),
      .prev   (prev_y_ff),
      .smooth (lane_y)
   );

   tes_ema_lane u_lane_yaw (
      .alpha  (cfg.alpha_angular),
      .cmd    (cur_yaw),
      .prev   (prev_yaw_ff),
      .smooth (lane_yaw)
   );

   always_comb begin
      s1_valid_in   = req_ready ? req_valid : s1_valid_ff;

      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_yaw_in   = held_yaw_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_yaw_in   = prev_yaw_ff;
      hold_count_in = hold_count_ff;

      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;

      if (cmd_fire) begin
         // new command: latch velocities, reload the timer
         held_x_in     = s1_word_ff.vel_x;
         held_y_in     = s1_word_ff.vel_y;
         held_yaw_in   = s1_word_ff.vel_yaw;
         hold_count_in = cfg.hold_ticks;
      end else if (tick_fire) begin
         held_x_in     = cur_x;
         held_y_in     = cur_y;
         held_yaw_in   = cur_yaw;
         if (!timed_out) begin
            hold_count_in = hold_count_ff - HOLD_WIDTH'(1);
         end
         prev_x_in              = lane_x;
         prev_y_in              = lane_y;
         prev_yaw_in            = lane_yaw;
         rsp_valid_in           = 1'b1;
         rsp_word_in.smooth_x   = lane_x;
         rsp_word_in.smooth_y   = lane_y;
         rsp_word_in.smooth_yaw = lane_yaw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         held_yaw_ff   <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_yaw_ff   <= '0;
         hold_count_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_yaw_ff   <= held_yaw_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_yaw_ff   <= prev_yaw_in;
         hold_count_ff <= hold_count_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_word_ff <= req_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A result only ever appears from a tick word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tick_fire))
      else $error("result raised without a tick");

   // A tick must not retire while the pending result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !tick_fire)
      else $error("tick retired over a stalled result");

   // A live counter counts down by one on each tick
   assert property (@(posedge clock) disable iff (reset)
      (tick_fire && !timed_out) |=> (hold_count_ff == $past(hold_count_ff) - HOLD_WIDTH'(1)))
      else $error("hold counter did not decrement");

   // A tick after timeout leaves the held command cleared
   assert property (@(posedge clock) disable iff (reset)
      (tick_fire && timed_out) |=>
         (held_x_ff == '0 && held_y_ff == '0 && held_yaw_ff == '0))
      else $error("held command not cleared on timeout");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the twist EMA smoother: directed words, then random phases.
`timescale 1ns / 1ps

module tb_top;
   import tes_pkg::*;

   // ---------------------------------------------------------------------
   // Clock, reset and the ports of the block
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;

   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_ALPHA_LINEAR;
   logic [ALPHA_WIDTH-1:0]     csr_data  = '0;

   always #5 clock = ~clock;

   twist_ema_smoother_with_timeout dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   req_word_type word_queue[$];     // words waiting to be offered
   rsp_word_type smoothed_due[$];   // predicted results, oldest first
   int           mismatches = 0;

   // Idling knobs, set by the sequencer between phases (percent of cycles)
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          pressure_on = 1'b0;

   // Long receiver hold-off, owned by the monitor
   int unsigned stall_left = 0;
   bit          long_stall_done = 1'b0;

   // Shadow of the block: configuration plus held command, smoothed values, counter
   cfg_type                shadow_cfg = '{ALPHA_RESET, ALPHA_RESET, HOLD_RESET};
   vel_type                held_x = '0, held_y = '0, held_yaw = '0;
   vel_type                last_x = '0, last_y = '0, last_yaw = '0;
   logic [HOLD_WIDTH-1:0]  hold_left = '0;

   rsp_word_type want;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // One EMA lane: weight clamped to one, add a half, floor, then saturate.
   function automatic vel_type ema_lane(logic [ALPHA_WIDTH-1:0] alpha, vel_type target,
                                        vel_type last);
      longint one, hi, lo, a, acc, q;
      one = longint'(1) << FRAC_BITS;
      hi  = (longint'(1) << (VEL_WIDTH - 1)) - 1;
      lo  = -hi - 1;
      a   = (longint'(alpha) > one) ? one : longint'(alpha);
      acc = a * longint'(target) + (one - a) * longint'(last) + (one >> 1);
      q   = acc >>> FRAC_BITS;   // arithmetic shift: floor for negatives too
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return vel_type'(q);
   endfunction

   // Advance the shadow by one accepted word; ticks queue a smoothed result.
   task automatic smooth_word(input req_word_type w);
      rsp_word_type r;
      if (w.mode == MODE_COMMAND) begin
         held_x    = w.vel_x;
         held_y    = w.vel_y;
         held_yaw  = w.vel_yaw;
         hold_left = shadow_cfg.hold_ticks;
      end else begin
         // timeout: counter already spent, so the command drops to zero
         if (hold_left == '0) begin
            held_x   = '0;
            held_y   = '0;
            held_yaw = '0;
         end else begin
            hold_left = hold_left - 1'b1;
         end
         last_x   = ema_lane(shadow_cfg.alpha_linear,  held_x,   last_x);
         last_y   = ema_lane(shadow_cfg.alpha_linear,  held_y,   last_y);
         last_yaw = ema_lane(shadow_cfg.alpha_angular, held_yaw, last_yaw);
         r.smooth_x   = last_x;
         r.smooth_y   = last_y;
         r.smooth_yaw = last_yaw;
         smoothed_due.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued words, holds each until accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) smooth_word(req_word);
         // slot free once nothing is offered or the offer has just gone in
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= word_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: drives rsp_ready, checks every accepted result
   // ---------------------------------------------------------------------
   task automatic check_lane(input string lane, input vel_type exp_v, input vel_type got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, lane,
                  exp_v, exp_v, got_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (smoothed_due.size() == 0) begin
            $display("%0t: result with nothing expected: %h", $time, rsp_word);
            mismatches++;
         end else begin
            want = smoothed_due.pop_front();
            check_lane("smooth_x",   want.smooth_x,   rsp_word.smooth_x);
            check_lane("smooth_y",   want.smooth_y,   rsp_word.smooth_y);
            check_lane("smooth_yaw", want.smooth_yaw, rsp_word.smooth_yaw);
         end
      end

      // ready: long hold-off first, then random stalls
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (pressure_on && !long_stall_done) begin
         rsp_ready       <= 1'b0;
         stall_left      <= 400;
         long_stall_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer helpers
   // ---------------------------------------------------------------------
   task automatic push_cmd(input vel_type x, input vel_type y, input vel_type yaw);
      req_word_type w;
      w.mode    = MODE_COMMAND;
      w.vel_x   = x;
      w.vel_y   = y;
      w.vel_yaw = yaw;
      word_queue.push_back(w);
   endtask

   // Tick with junk in the velocity fields, which the block must ignore
   task automatic push_tick(input vel_type junk);
      req_word_type w;
      w.mode    = MODE_TICK;
      w.vel_x   = junk;
      w.vel_y   = ~junk;
      w.vel_yaw = vel_type'($urandom);
      word_queue.push_back(w);
   endtask

   function automatic vel_type rand_vel();
      case ($urandom_range(7))
         0: return vel_type'(32767);
         1: return vel_type'(-32768);
         2: return vel_type'(int'($urandom_range(63)) - 32);
         default: return vel_type'($urandom);
      endcase
   endfunction

   // Mostly command-then-ticks bursts, some long enough to run into the timeout,
   // with some noise words of random mode.
   task automatic fill_random(input int n);
      int added;
      int k;
      int cap;
      req_word_type w;
      added = 0;
      while (added < n) begin
         if ($urandom_range(9) < 8) begin
            push_cmd(rand_vel(), rand_vel(), rand_vel());
            cap = int'(shadow_cfg.hold_ticks) + 3;
            if (cap > 20) cap = 20;
            k = $urandom_range(cap);
            repeat (k) push_tick(vel_type'($urandom));
            added += k + 1;
         end else begin
            w = req_word_type'({$urandom, $urandom});
            word_queue.push_back(w);
            added++;
         end
      end
   endtask

   // Wait until every word is in and every result out, then let a command
   // still in the input register settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (word_queue.size() != 0 || req_valid || smoothed_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [ALPHA_WIDTH-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      case (idx)
         CSR_ALPHA_LINEAR:  shadow_cfg.alpha_linear  = val;
         CSR_ALPHA_ANGULAR: shadow_cfg.alpha_angular = val;
         CSR_HOLD_TICKS:    shadow_cfg.hold_ticks    = val[HOLD_WIDTH-1:0];
         default: ;   // unused index: no register behind it
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset settings (0.4, hold 10)
      set_idling(0, 0);
      push_tick('0);                    // counter at reset: smooths towards zero
      push_tick(vel_type'(16'hFFFF));   // velocity fields ignored on a tick
      push_cmd(vel_type'(32767), vel_type'(-32768), vel_type'(-1));
      repeat (2) push_tick('0);
      push_cmd(vel_type'(-32768), vel_type'(32767), '0);
      repeat (11) push_tick(vel_type'(16'h5A5A));   // eleventh tick hits the timeout
      wait_drained();

      // Weight exactly one, zero hold ticks: cleared on the first tick
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_ONE);
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_ONE);
      write_csr(CSR_HOLD_TICKS,    '0);
      push_cmd(vel_type'(32767), vel_type'(-32768), vel_type'(12345));
      repeat (2) push_tick('0);
      wait_drained();

      // Weight register above one, treated as one
      write_csr(CSR_ALPHA_LINEAR,  '1);
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_ONE + 1'b1);
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'(2));
      push_cmd(vel_type'(-32768), vel_type'(32767), vel_type'(1));
      repeat (3) push_tick(vel_type'(-1));
      wait_drained();

      // Random weights from zero to one, no idling
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'($urandom_range(12)));
      fill_random(140);
      wait_drained();

      // Weight zero and just under one, zero hold; sender idling, with a
      // pause in the middle until every result is back
      write_csr(CSR_ALPHA_LINEAR,  '0);
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_ONE - 1'b1);
      write_csr(CSR_HOLD_TICKS,    '0);
      set_idling(64, 0);
      fill_random(70);
      wait_drained();
      fill_random(70);
      wait_drained();

      // Smallest weights, longest hold; receiver stalling. One burst runs
      // past the full 255 ticks.
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'(1));
      write_csr(CSR_ALPHA_ANGULAR, '0);
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'(255));
      set_idling(0, 64);
      push_cmd(rand_vel(), rand_vel(), rand_vel());
      repeat (258) push_tick(vel_type'($urandom));
      fill_random(60);
      wait_drained();

      // Both sides idling
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'(5));
      set_idling(33, 33);
      fill_random(140);
      wait_drained();

      // Backpressure: receiver holds off long while the sender keeps offering
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'($urandom_range(8)));
      set_idling(0, 0);
      pressure_on = 1'b1;
      fill_random(140);
      wait_drained();
      pressure_on = 1'b0;

      // Whole register ranges, junk in the unused hold bits, the spare index
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'($urandom));
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_WIDTH'($urandom));
      write_csr(CSR_HOLD_TICKS,    {ALPHA_WIDTH'($urandom) >> HOLD_WIDTH << HOLD_WIDTH}
                                   | ALPHA_WIDTH'($urandom_range(15)));
      write_csr(CSR_INDEX_WIDTH'(3), ALPHA_WIDTH'($urandom));
      set_idling(33, 33);
      fill_random(130);
      wait_drained();

      // Final stretch with no idling
      write_csr(CSR_ALPHA_LINEAR,  ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_ALPHA_ANGULAR, ALPHA_WIDTH'($urandom_range(65536)));
      write_csr(CSR_HOLD_TICKS,    ALPHA_WIDTH'($urandom_range(6)));
      set_idling(0, 0);
      fill_random(50);
      wait_drained();

      // Catch any stray result before judging
      repeat (10) @(posedge clock);
      if (mismatches == 0 && smoothed_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         if (smoothed_due.size() != 0)
            $display("%0t: %0d results never arrived", $time, smoothed_due.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
